### src/asc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types and constants for the escape sequence stripper: byte codes,
// parser modes, the per-byte class flags and the queue word.
// ----------------------------------------------------------------------------
package asc_pkg;

    // Byte codes the parser reacts to
    localparam logic [7:0] BYTE_ESC     = 8'h1b;
    localparam logic [7:0] BYTE_BEL     = 8'h07;
    localparam logic [7:0] CSI_FINAL_LO = 8'h40;
    localparam logic [7:0] CSI_FINAL_HI = 8'h7e;
    localparam logic [7:0] BYTE_LBRACK  = 8'h5b;
    localparam logic [7:0] BYTE_RBRACK  = 8'h5d;
    localparam logic [7:0] BYTE_BSLASH  = 8'h5c;

    // Depth of the queue between front and back
    localparam int ASC_QUEUE_DEPTH = 2;

    // Parser modes
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_CSI     = 3'd2,
        MODE_OSC     = 3'd3,
        MODE_OSC_ESC = 3'd4
    } t_parse_mode;

    // Byte class flags; several may be set at once (brackets are also finals)
    typedef struct packed {
        logic is_esc;
        logic is_bel;
        logic is_lbrack;
        logic is_rbrack;
        logic is_bslash;
        logic is_final;
    } t_byte_class;

    // One queued word: raw byte, chunk restart and its class
    typedef struct packed {
        logic [7:0]  data;
        logic        restart;
        t_byte_class cls;
    } t_item;

endpackage

### src/asc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_front
// Input side: takes a word when the queue has room and classifies the byte.
// ----------------------------------------------------------------------------
module asc_front (
    input  logic          i_in_valid,
    input  logic [7:0]    i_in_byte,
    input  logic          i_chunk_start,
    output logic          o_in_stall,
    input  logic          i_q_full,
    output logic          o_push,
    output asc_pkg::t_item o_item
);
    import asc_pkg::*;

    // Handshake: stall only while the queue is full
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

    // Classify the byte
    always_comb begin
        o_item.data          = i_in_byte;
        o_item.restart       = i_chunk_start;
        o_item.cls.is_esc    = (i_in_byte == BYTE_ESC);
        o_item.cls.is_bel    = (i_in_byte == BYTE_BEL);
        o_item.cls.is_lbrack = (i_in_byte == BYTE_LBRACK);
        o_item.cls.is_rbrack = (i_in_byte == BYTE_RBRACK);
        o_item.cls.is_bslash = (i_in_byte == BYTE_BSLASH);
        o_item.cls.is_final  = (i_in_byte >= CSI_FINAL_LO) && (i_in_byte <= CSI_FINAL_HI);
    end

endmodule

### src/asc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_queue
// Short register FIFO between the classifier and the parser.
// ----------------------------------------------------------------------------
module asc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  asc_pkg::t_item i_item,
    input  logic           i_pop,
    output asc_pkg::t_item o_item,
    output logic           o_full,
    output logic           o_empty
);
    import asc_pkg::*;

    localparam int PTR_W = (ASC_QUEUE_DEPTH > 1) ? $clog2(ASC_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ASC_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ASC_QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ASC_QUEUE_DEPTH);

    t_item            r_mem [ASC_QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### src/asc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_back
// Parser state machine: consumes classified words and registers text bytes.
// ----------------------------------------------------------------------------
module asc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  asc_pkg::t_item i_item,
    input  logic           i_q_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    output logic [7:0]     o_text_byte,
    input  logic           i_out_stall
);
    import asc_pkg::*;

    t_parse_mode r_mode, n_mode, cur_mode;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_text_byte;
    logic        out_free;
    logic        emit;

    // Output register can take a word when empty or being drained
    assign out_free = ~r_out_valid | ~i_out_stall;
    assign o_pop    = ~i_q_empty & out_free;

    // Next mode and emit decision
    always_comb begin
        cur_mode = i_item.restart ? MODE_NORMAL : r_mode;
        n_mode   = cur_mode;
        emit     = 1'b0;
        case (cur_mode)
            MODE_NORMAL: begin
                if (i_item.cls.is_esc) n_mode = MODE_ESC;
                else                   emit   = 1'b1;
            end
            MODE_ESC: begin
                if (i_item.cls.is_lbrack)      n_mode = MODE_CSI;
                else if (i_item.cls.is_rbrack) n_mode = MODE_OSC;
                else                           n_mode = MODE_NORMAL;
            end
            MODE_CSI: begin
                if (i_item.cls.is_final) n_mode = MODE_NORMAL;
            end
            MODE_OSC: begin
                if (i_item.cls.is_bel)      n_mode = MODE_NORMAL;
                else if (i_item.cls.is_esc) n_mode = MODE_OSC_ESC;
            end
            MODE_OSC_ESC: begin
                if (i_item.cls.is_bslash)   n_mode = MODE_NORMAL;
                else if (!i_item.cls.is_esc) n_mode = MODE_OSC;
            end
            default: begin
                // unused codes behave as normal text
                if (i_item.cls.is_esc) n_mode = MODE_ESC;
                else                   emit   = 1'b1;
            end
        endcase

        n_out_valid = r_out_valid & i_out_stall;
        if (o_pop && emit) n_out_valid = 1'b1;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NORMAL;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) r_mode <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    // Output data
    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_text_byte <= i_item.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_text_byte = r_text_byte;

endmodule

### src/ansi_escape_stripper.sv
`timescale 1ns / 1ps
// A byte accepted by the block is first written into the queue, then parsed into the output
//   register, from which it shows on o_text_byte.
// Throughput: one byte per clock while the receiver does not stall the output.
// Reset (i_rst_n low, synchronous): queue empties, parser returns to normal text,
//   output word is dropped.
// ----------------------------------------------------------------------------
// ansi_escape_stripper
// Filters a terminal byte stream, dropping CSI, OSC and two-byte ESC sequences
// and passing plain text through. Classifier and parser are split by a queue.
// ----------------------------------------------------------------------------
module ansi_escape_stripper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_chunk_start,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output logic [7:0] o_text_byte,
    input  logic       i_out_stall
);
    import asc_pkg::*;

    t_item fr_item, q_item;
    logic  push, pop, q_full, q_empty;

    // Front: accept and classify
    asc_front u_front (
        .i_in_valid    (i_in_valid),
        .i_in_byte     (i_in_byte),
        .i_chunk_start (i_chunk_start),
        .o_in_stall    (o_in_stall),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_item        (fr_item)
    );

    // Queue between the two sides
    asc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (fr_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: parse and emit text
    asc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (q_item),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_text_byte (o_text_byte),
        .i_out_stall (i_out_stall)
    );

endmodule

### tb/sv/ansi_escape_stripper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_escape_stripper_tb
// Self-checking bench for the escape sequence stripper. A directed table walks
// the parser through every mode and corner. A random part follows, made of
// well-formed CSI/OSC/ESC sequences with random content, mixed with noise and
// sequences broken by a chunk restart. Each accepted word is run through a
// local parser model, and every text word that comes out is compared in order.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module ansi_escape_stripper_tb;
    import asc_pkg::*;

    localparam int DIR_ROWS    = 27;
    localparam int RAND_WORDS  = 550;
    localparam int DRAIN_AT    = DIR_ROWS + 350;   // mid-run pause until idle
    localparam int HOLD_AT     = DIR_ROWS + 150;   // long receiver hold-off
    localparam int HOLD_CYCLES = 60;

    // One directed row; fixed marks a text word typed in by hand
    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       fixed;
        logic [7:0] text;
    } t_dir_row;

    // One queued stimulus word
    typedef struct {
        logic [7:0] data;
        logic       restart;
        logic       fixed;
        logic [7:0] text;
    } t_tx_word;

    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // extremes pass straight through after reset
        '{8'h00,        1'b0, 1'b1, 8'h00},
        '{8'hff,        1'b0, 1'b1, 8'hff},
        // ESC plus an ordinary byte drops both
        '{BYTE_ESC,     1'b0, 1'b0, 8'h00},
        '{8'h41,        1'b0, 1'b0, 8'h00},
        // CSI with ESC as a parameter, non-finals on both sides, final at low end
        '{BYTE_ESC,     1'b0, 1'b0, 8'h00},
        '{BYTE_LBRACK,  1'b0, 1'b0, 8'h00},
        '{BYTE_ESC,     1'b0, 1'b0, 8'h00},
        '{8'h3f,        1'b0, 1'b0, 8'h00},
        '{8'h7f,        1'b0, 1'b0, 8'h00},
        '{CSI_FINAL_LO, 1'b0, 1'b0, 8'h00},
        // CSI ending on the high final
        '{BYTE_ESC,     1'b0, 1'b0, 8'h00},
        '{BYTE_LBRACK,  1'b0, 1'b0, 8'h00},
        '{CSI_FINAL_HI, 1'b0, 1'b0, 8'h00},
        // OSC: ESC ESC stays in ESC-seen, other byte returns, BEL ends
        '{BYTE_ESC,     1'b0, 1'b0, 8'h00},
        '{BYTE_RBRACK,  1'b0, 1'b0, 8'h00},
        '{8'h41,        1'b0, 1'b0, 8'h00},
        '{BYTE_ESC,     1'b0, 1'b0, 8'h00},
        '{BYTE_ESC,     1'b0, 1'b0, 8'h00},
        '{8'h42,        1'b0, 1'b0, 8'h00},
        '{BYTE_BEL,     1'b0, 1'b0, 8'h00},
        // OSC ended by string terminator
        '{BYTE_ESC,     1'b0, 1'b0, 8'h00},
        '{BYTE_RBRACK,  1'b0, 1'b0, 8'h00},
        '{BYTE_ESC,     1'b0, 1'b0, 8'h00},
        '{BYTE_BSLASH,  1'b0, 1'b0, 8'h00},
        // control byte in normal mode passes
        '{8'h0a,        1'b0, 1'b0, 8'h00},
        // chunk restart cancels a pending ESC
        '{BYTE_ESC,     1'b0, 1'b0, 8'h00},
        '{8'h78,        1'b1, 1'b1, 8'h78}
    };

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] in_byte     = 8'h00;
    logic       chunk_start = 1'b0;
    logic       out_stall   = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_text_byte;

    t_tx_word    stim_q[$];
    logic [7:0]  text_q[$];
    t_parse_mode parser_mode = MODE_NORMAL;
    int          word_idx    = 0;
    int          err_cnt     = 0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    int          phase_left  = 0;
    int          stall_style = 0;

    ansi_escape_stripper dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_byte     (in_byte),
        .i_chunk_start (chunk_start),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_text_byte   (o_text_byte),
        .i_out_stall   (out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Parser model: advance one word, return 1 when a text word comes out
    function automatic logic strip_step(input logic [7:0] c, input logic restart,
                                        output logic [7:0] text);
        t_parse_mode m;
        logic        emit;
        m    = restart ? MODE_NORMAL : parser_mode;
        emit = 1'b0;
        text = c;
        case (m)
            MODE_NORMAL: begin
                if (c == BYTE_ESC) m = MODE_ESC;
                else emit = 1'b1;
            end
            MODE_ESC: begin
                if (c == BYTE_LBRACK) m = MODE_CSI;
                else if (c == BYTE_RBRACK) m = MODE_OSC;
                else m = MODE_NORMAL;
            end
            MODE_CSI: begin
                if (c >= CSI_FINAL_LO && c <= CSI_FINAL_HI) m = MODE_NORMAL;
            end
            MODE_OSC: begin
                if (c == BYTE_BEL) m = MODE_NORMAL;
                else if (c == BYTE_ESC) m = MODE_OSC_ESC;
            end
            MODE_OSC_ESC: begin
                if (c == BYTE_BSLASH) m = MODE_NORMAL;
                else if (c != BYTE_ESC) m = MODE_OSC;
            end
            default: begin
                // unused codes behave as normal text
                if (c == BYTE_ESC) m = MODE_ESC;
                else begin
                    m    = MODE_NORMAL;
                    emit = 1'b1;
                end
            end
        endcase
        parser_mode = m;
        return emit;
    endfunction

    task automatic push_word(input logic [7:0] data, input logic restart);
        t_tx_word w;
        w.data    = data;
        w.restart = restart;
        w.fixed   = 1'b0;
        w.text    = 8'h00;
        stim_q.push_back(w);
    endtask

    // Random traffic: mostly well-formed sequences, some noise and broken ones
    task automatic gen_random(input int n_words);
        int         base;
        int         kind;
        int         len;
        logic [7:0] b;
        logic       first_rs;
        base = stim_q.size();
        while (stim_q.size() - base < n_words) begin
            kind     = $urandom_range(0, 99);
            first_rs = ($urandom_range(0, 24) == 0);
            if (kind < 30) begin
                // plain text run
                len = $urandom_range(1, 10);
                for (int k = 0; k < len; k++) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == BYTE_ESC) b = 8'h20;
                    push_word(b, (k == 0) ? first_rs : 1'b0);
                end
            end else if (kind < 50) begin
                // CSI with parameter bytes, now and then an ESC among them
                push_word(BYTE_ESC, first_rs);
                push_word(BYTE_LBRACK, 1'b0);
                len = $urandom_range(0, 5);
                for (int k = 0; k < len; k++) begin
                    b = ($urandom_range(0, 9) == 0) ? BYTE_ESC
                                                    : 8'($urandom_range(8'h20, 8'h3f));
                    push_word(b, 1'b0);
                end
                push_word(8'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI)), 1'b0);
            end else if (kind < 65) begin
                // OSC with random payload and embedded ESC pairs
                push_word(BYTE_ESC, first_rs);
                push_word(BYTE_RBRACK, 1'b0);
                len = $urandom_range(0, 8);
                for (int k = 0; k < len; k++) begin
                    b = 8'($urandom_range(8'h20, 8'h7e));
                    if ($urandom_range(0, 5) == 0) begin
                        push_word(BYTE_ESC, 1'b0);
                        if ($urandom_range(0, 1)) push_word(BYTE_ESC, 1'b0);
                        if (b == BYTE_BSLASH) b = 8'h78;
                    end
                    push_word(b, 1'b0);
                end
                if ($urandom_range(0, 1)) begin
                    push_word(BYTE_BEL, 1'b0);
                end else begin
                    push_word(BYTE_ESC, 1'b0);
                    push_word(BYTE_BSLASH, 1'b0);
                end
            end else if (kind < 75) begin
                // two-word escape
                b = 8'($urandom_range(0, 255));
                if (b == BYTE_LBRACK || b == BYTE_RBRACK) b = 8'h63;
                push_word(BYTE_ESC, first_rs);
                push_word(b, 1'b0);
            end else if (kind < 90) begin
                // noise, biased toward the bytes the parser reacts to
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 9))
                        0:       b = BYTE_ESC;
                        1:       b = BYTE_BEL;
                        2:       b = BYTE_LBRACK;
                        3:       b = BYTE_RBRACK;
                        4:       b = BYTE_BSLASH;
                        5:       b = ($urandom_range(0, 1)) ? CSI_FINAL_LO : CSI_FINAL_HI;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    push_word(b, (k == 0) ? first_rs : ($urandom_range(0, 7) == 0));
                end
            end else begin
                // sequence cut short by a new chunk
                push_word(BYTE_ESC, first_rs);
                if ($urandom_range(0, 2) != 0)
                    push_word($urandom_range(0, 1) ? BYTE_LBRACK : BYTE_RBRACK, 1'b0);
                len = $urandom_range(0, 3);
                for (int k = 0; k < len; k++)
                    push_word(8'($urandom_range(8'h20, 8'h3f)), 1'b0);
                push_word(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    // Sender: bursts and gaps; predicts each word as it is accepted
    always @(posedge i_clk) begin : word_driver
        int         nxt;
        logic [7:0] txt;
        logic       hit;
        nxt = word_idx;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                hit = strip_step(in_byte, chunk_start, txt);
                if (stim_q[word_idx].fixed) text_q.push_back(stim_q[word_idx].text);
                else if (hit) text_q.push_back(txt);
                nxt = word_idx + 1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (nxt >= stim_q.size() ||
                             ((nxt == DIR_ROWS || nxt == DRAIN_AT) && text_q.size() != 0)) begin
                    in_valid <= 1'b0;
                end else begin
                    in_valid    <= 1'b1;
                    in_byte     <= stim_q[nxt].data;
                    chunk_start <= stim_q[nxt].restart;
                end
            end
            word_idx <= nxt;
        end
    end

    // Receiver stall pattern, with one long hold-off to back up the block
    always @(posedge i_clk) begin : stall_gen
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (!hold_done && word_idx >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (phase_left == 0) begin
                    stall_style = $urandom_range(0, 3);
                    phase_left  = $urandom_range(16, 80);
                end
                phase_left--;
                case (stall_style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Compare each text word with the oldest prediction
    always @(posedge i_clk) begin : text_check
        logic [7:0] want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (text_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected text word: expected none, actual %02h",
                         $time, o_text_byte);
            end else begin
                want = text_q.pop_front();
                if (o_text_byte !== want) begin
                    err_cnt++;
                    $display("%0t: text word mismatch: expected %02h, actual %02h",
                             $time, want, o_text_byte);
                end
            end
        end
    end

    initial begin : main_seq
        t_tx_word w;
        int       waited;
        for (int i = 0; i < DIR_ROWS; i++) begin
            w.data    = DIR_TABLE[i].data;
            w.restart = DIR_TABLE[i].restart;
            w.fixed   = DIR_TABLE[i].fixed;
            w.text    = DIR_TABLE[i].text;
            stim_q.push_back(w);
        end
        gen_random(RAND_WORDS);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_idx < stim_q.size() || in_valid) @(posedge i_clk);
        waited = 0;
        while (text_q.size() != 0 && waited < 500) begin
            @(posedge i_clk);
            waited++;
        end
        if (text_q.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d text words never arrived: expected %02h, actual none",
                     $time, text_q.size(), text_q[0]);
        end
        repeat (8) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
